[src/trs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and codes for the tagged record store.
// ----------------------------------------------------------------------------
package trs_pkg;

  // default store size in bytes
  localparam int unsigned StoreBytesDef = 4096;
  // width of a byte position, wide enough for a walk that runs past the store
  localparam int unsigned PosW = 18;
  // header length in bytes
  localparam int unsigned HdrBytes = 4;

  // operation codes
  localparam logic [2:0] OpCreate = 3'd0;
  localparam logic [2:0] OpDelete = 3'd1;
  localparam logic [2:0] OpGet    = 3'd2;
  localparam logic [2:0] OpPut    = 3'd3;
  localparam logic [2:0] OpInval  = 3'd4;

  // status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StDup      = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StOverflow = 3'd3;
  localparam logic [2:0] StNoSpace  = 3'd4;
  localparam logic [2:0] StInvalid  = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] rec_id;
    logic [15:0] body_offset;
    logic [15:0] body_size;
    logic [7:0]  wr_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] rd_byte;
  } out_t;

  typedef enum logic [3:0] {
    StIdle,
    StWalk,
    StDecide,
    StCrWr,
    StDlRd,
    StDlWr,
    StDlZero,
    StGpRd,
    StGpWait,
    StDone
  } state_e;

endpackage
`default_nettype wire

[src/tagged_record_store.sv]
`default_nettype none
// Sequence: ops that need no lookup go straight to the result; otherwise a
// header walk reads each record header, then create writes each header and body
// byte, delete moves later bytes down and zero-fills the freed tail, get/put
// read or write one byte. Worst case: a walk over 4-byte headers, then a full move.
// One item in flight; the next beat is taken while a result waits at the output.
// Reset: no clearing pass; a fill mark (used length) makes bytes at or above it read 0.
// ----------------------------------------------------------------------------
// tagged_record_store
// Byte store of tagged records with create, delete, byte get/put, invalidate.
// ----------------------------------------------------------------------------
module tagged_record_store #(
  parameter int unsigned STORE_BYTES = trs_pkg::StoreBytesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire trs_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output trs_pkg::out_t      out_data_o
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned UW = $clog2(STORE_BYTES + 1);
  localparam int unsigned PW = trs_pkg::PosW;
  localparam logic [PW-1:0] HdrP   = PW'(trs_pkg::HdrBytes);
  localparam logic [PW-1:0] StoreP = PW'(STORE_BYTES);

  // byte memory
  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;
  logic       rin_q;
  logic          mem_re, mem_we;
  logic [PW-1:0] mem_ra, mem_wa;
  logic [7:0]    mem_wd;
  logic [7:0]    rbyte;

  trs_pkg::state_e state_q, state_d;
  logic [2:0]    op_q, op_d;
  logic [15:0]   id_q, id_d, off_q, off_d, req_q, req_d;
  logic [7:0]    wb_q, wb_d;
  logic [PW-1:0] p_q, p_d, cur_q, cur_d, tail_q, tail_d;
  logic [PW-1:0] w_q, w_d, s_q, s_d, e_q, e_d;
  logic [2:0]    k_q, k_d;
  logic [7:0]    hb_q [3];
  logic [7:0]    hb_d [3];
  logic          found_q, found_d;
  logic [15:0]   csize_q, csize_d;
  logic [UW-1:0] used_q, used_d;
  logic          valid_q, valid_d;
  logic [2:0]    st_q, st_d;
  logic [7:0]    rb_q, rb_d;
  logic          ov_q, ov_d;
  trs_pkg::out_t od_q, od_d;

  // scratch
  logic [15:0]   hid, hsz;
  logic [16:0]   rsize;
  logic [PW-1:0] endp, nxt, diff, usedp;

  assign usedp = PW'(used_q);

  // memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa[AW-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra[AW-1:0]];
      rin_q   <= (mem_ra < usedp);
    end
  end

  // bytes at or above the used length read as zero
  assign rbyte = rin_q ? rdata_q : 8'd0;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trs_pkg::StIdle;
      used_q  <= '0;
      valid_q <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      valid_q <= valid_d;
      ov_q    <= ov_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    id_q    <= id_d;
    off_q   <= off_d;
    req_q   <= req_d;
    wb_q    <= wb_d;
    p_q     <= p_d;
    cur_q   <= cur_d;
    tail_q  <= tail_d;
    w_q     <= w_d;
    s_q     <= s_d;
    e_q     <= e_d;
    k_q     <= k_d;
    hb_q    <= hb_d;
    found_q <= found_d;
    csize_q <= csize_d;
    st_q    <= st_d;
    rb_q    <= rb_d;
    od_q    <= od_d;
  end

  assign in_stall_o  = (state_q != trs_pkg::StIdle);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d = op_q;   id_d = id_q;   off_d = off_q;  req_d = req_q;  wb_d = wb_q;
    p_d = p_q;     cur_d = cur_q; tail_d = tail_q; w_d = w_q;  s_d = s_q;
    e_d = e_q;     k_d = k_q;     hb_d = hb_q;    found_d = found_q;
    csize_d = csize_q; used_d = used_q; valid_d = valid_q;
    st_d = st_q;   rb_d = rb_q;   od_d = od_q;
    ov_d = ov_q && out_stall_i;
    mem_re = 1'b0; mem_ra = p_q;
    mem_we = 1'b0; mem_wa = w_q; mem_wd = 8'd0;
    hid   = {hb_q[1], hb_q[0]};
    hsz   = {rbyte, hb_q[2]};
    rsize = (17'({1'b0, req_q}) + 17'd3) & 17'h1fffc;
    endp  = tail_q + HdrP + PW'(rsize);
    nxt   = cur_q + HdrP + PW'(csize_q);
    diff  = w_q - cur_q;

    unique case (state_q)
      trs_pkg::StIdle: begin
        if (in_valid_i) begin
          op_d  = in_data_i.op;
          id_d  = in_data_i.rec_id;
          off_d = in_data_i.body_offset;
          req_d = in_data_i.body_size;
          wb_d  = in_data_i.wr_byte;
          rb_d  = 8'd0;
          st_d  = trs_pkg::StOk;
          state_d = trs_pkg::StDone;
          priority if (in_data_i.op == trs_pkg::OpInval) begin
            valid_d = 1'b0;
          end else if (in_data_i.op > trs_pkg::OpInval) begin
            st_d = trs_pkg::StOk;
          end else if (!valid_q) begin
            st_d = trs_pkg::StInvalid;
          end else if (in_data_i.rec_id == 16'd0) begin
            st_d = (in_data_i.op == trs_pkg::OpCreate) ? trs_pkg::StDup
                                                       : trs_pkg::StNotFound;
          end else begin
            p_d = '0;
            k_d = 3'd0;
            found_d = 1'b0;
            state_d = trs_pkg::StWalk;
          end
        end
      end

      // header walk: read 4 bytes, then step over the record
      trs_pkg::StWalk: begin
        if (k_q == 3'd0 && p_q >= usedp) begin
          tail_d  = usedp;
          state_d = trs_pkg::StDecide;
        end else if (k_q == 3'd4) begin
          k_d = 3'd0;
          if (hid == 16'd0) begin
            tail_d  = p_q;
            state_d = trs_pkg::StDecide;
          end else begin
            if (hid == id_q && !found_q) begin
              found_d = 1'b1;
              cur_d   = p_q;
              csize_d = hsz;
            end
            p_d = p_q + HdrP + PW'(hsz);
          end
        end else begin
          mem_re = 1'b1;
          mem_ra = p_q + PW'(k_q);
          if (k_q != 3'd0) begin
            hb_d[k_q[1:0] - 2'd1] = rbyte;
          end
          k_d = k_q + 3'd1;
        end
      end

      trs_pkg::StDecide: begin
        state_d = trs_pkg::StDone;
        priority case (op_q)
          trs_pkg::OpCreate: begin
            priority if (found_q) begin
              st_d = trs_pkg::StDup;
            end else if (rsize[16] || endp > StoreP) begin
              st_d = trs_pkg::StNoSpace;
            end else begin
              cur_d   = tail_q;
              w_d     = tail_q;
              e_d     = endp;
              csize_d = rsize[15:0];
              state_d = trs_pkg::StCrWr;
            end
          end
          trs_pkg::OpDelete: begin
            if (!found_q) begin
              st_d = trs_pkg::StNotFound;
            end else begin
              s_d = (nxt > tail_q) ? tail_q : nxt;
              w_d = cur_q;
              state_d = (((nxt > tail_q) ? tail_q : nxt) < tail_q) ?
                        trs_pkg::StDlRd : trs_pkg::StDlZero;
            end
          end
          default: begin
            priority if (!found_q) begin
              st_d = trs_pkg::StNotFound;
            end else if (off_q >= csize_q) begin
              st_d = trs_pkg::StOverflow;
            end else begin
              w_d = cur_q + HdrP + PW'(off_q);
              state_d = (op_q == trs_pkg::OpGet) ? trs_pkg::StGpRd
                                                 : trs_pkg::StGpWait;
            end
          end
        endcase
      end

      // create: header bytes then zeroed body
      trs_pkg::StCrWr: begin
        mem_we = 1'b1;
        unique case (diff[1:0])
          2'd0: mem_wd = id_q[7:0];
          2'd1: mem_wd = id_q[15:8];
          2'd2: mem_wd = csize_q[7:0];
          default: mem_wd = csize_q[15:8];
        endcase
        if (diff >= HdrP) mem_wd = 8'd0;
        w_d = w_q + PW'(1);
        if (w_q + PW'(1) == e_q) begin
          if (e_q > usedp) used_d = UW'(e_q);
          state_d = trs_pkg::StDone;
        end
      end

      // delete: move later records down
      trs_pkg::StDlRd: begin
        mem_re = 1'b1;
        mem_ra = s_q;
        state_d = trs_pkg::StDlWr;
      end

      trs_pkg::StDlWr: begin
        mem_we = 1'b1;
        mem_wd = rbyte;
        w_d = w_q + PW'(1);
        s_d = s_q + PW'(1);
        state_d = (s_q + PW'(1) < tail_q) ? trs_pkg::StDlRd : trs_pkg::StDlZero;
      end

      // delete: zero-fill the freed tail
      trs_pkg::StDlZero: begin
        if (w_q >= tail_q) begin
          state_d = trs_pkg::StDone;
        end else begin
          mem_we = 1'b1;
          mem_wd = 8'd0;
          w_d = w_q + PW'(1);
        end
      end

      trs_pkg::StGpRd: begin
        mem_re = 1'b1;
        mem_ra = w_q;
        state_d = trs_pkg::StGpWait;
      end

      // get captures the byte, put writes it
      trs_pkg::StGpWait: begin
        if (op_q == trs_pkg::OpGet) begin
          rb_d = rbyte;
        end else begin
          mem_we = 1'b1;
          mem_wd = wb_q;
        end
        state_d = trs_pkg::StDone;
      end

      trs_pkg::StDone: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          od_d = '{status: st_q, rd_byte: rb_q};
          state_d = trs_pkg::StIdle;
        end
      end

      default: state_d = trs_pkg::StIdle;
    endcase
  end

endmodule
`default_nettype wire

[test/tb_tagged_record_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_tagged_record_store
// Self-checking bench for the tagged record store: a behavioral copy of the
// store predicts status and read byte for every input beat; results are
// compared in order. Directed corner cases first, then random record traffic
// under three sender/receiver idling mixes, then a disable sequence.
// ----------------------------------------------------------------------------
module tb_tagged_record_store;

  localparam int unsigned StoreSz = 4096;

  // ---------------------------------------------------------------------------
  // scoreboard: shadow store plus queue of predicted results
  class store_scoreboard;
    byte unsigned    mem[StoreSz];
    int unsigned     used_len;
    bit              enabled;
    trs_pkg::out_t   pending[$];
    int              errors;
    int              n_checked;

    function new();
      foreach (mem[i]) mem[i] = 8'd0;
      used_len  = 0;
      enabled   = 1'b1;
      errors    = 0;
      n_checked = 0;
    endfunction

    function byte unsigned peek(int unsigned a);
      return (a < StoreSz) ? mem[a] : 8'd0;
    endfunction

    function void poke(int unsigned a, byte unsigned v);
      if (a < StoreSz) mem[a] = v;
    endfunction

    function int unsigned half(int unsigned a);
      return peek(a) | (int'(peek(a + 1)) << 8);
    endfunction

    // header walk; returns 1 and header address on a hit
    function bit lookup(int unsigned id, output int unsigned pos);
      int unsigned p;
      int unsigned hid;
      p = 0;
      pos = 0;
      while (p < used_len) begin
        hid = half(p);
        if (hid == id) begin
          pos = p;
          return 1'b1;
        end
        if (hid == 0) return 1'b0;
        p += trs_pkg::HdrBytes + half(p + 2);
      end
      return 1'b0;
    endfunction

    function logic [2:0] create_rec(int unsigned id, int unsigned req);
      int unsigned p, sz, fin;
      if (id == 0 || lookup(id, p)) return trs_pkg::StDup;
      sz = ((req + 3) >> 2) << 2;
      if (sz > 16'hFFFF) return trs_pkg::StNoSpace;
      if (!lookup(0, p)) p = used_len;
      fin = p + trs_pkg::HdrBytes + sz;
      if (fin > StoreSz) return trs_pkg::StNoSpace;
      poke(p, id[7:0]);
      poke(p + 1, id[15:8]);
      poke(p + 2, sz[7:0]);
      poke(p + 3, sz[15:8]);
      for (int unsigned i = p + trs_pkg::HdrBytes; i < fin; i++) poke(i, 8'd0);
      if (fin > used_len) used_len = fin;
      return trs_pkg::StOk;
    endfunction

    function logic [2:0] delete_rec(int unsigned id);
      int unsigned cur, tail, nxt, moved;
      if (id == 0 || !lookup(id, cur)) return trs_pkg::StNotFound;
      if (!lookup(0, tail)) tail = used_len;
      nxt = cur + trs_pkg::HdrBytes + half(cur + 2);
      if (nxt > tail) nxt = tail;
      moved = tail - nxt;
      for (int unsigned i = 0; i < moved; i++) poke(cur + i, peek(nxt + i));
      for (int unsigned i = cur + moved; i < tail; i++) poke(i, 8'd0);
      return trs_pkg::StOk;
    endfunction

    function logic [2:0] body_addr(int unsigned id, int unsigned off,
                                   output int unsigned addr);
      int unsigned p;
      addr = 0;
      if (id == 0 || !lookup(id, p)) return trs_pkg::StNotFound;
      if (off + 1 > half(p + 2)) return trs_pkg::StOverflow;
      addr = p + trs_pkg::HdrBytes + off;
      return trs_pkg::StOk;
    endfunction

    // note an accepted input beat and queue its predicted result
    function void note_input(trs_pkg::in_t it);
      trs_pkg::out_t r;
      int unsigned a;
      r = '0;
      if (it.op == trs_pkg::OpInval) enabled = 1'b0;
      else if (it.op <= trs_pkg::OpPut && !enabled) r.status = trs_pkg::StInvalid;
      else if (it.op == trs_pkg::OpCreate)
        r.status = create_rec(32'(it.rec_id), 32'(it.body_size));
      else if (it.op == trs_pkg::OpDelete) r.status = delete_rec(32'(it.rec_id));
      else if (it.op == trs_pkg::OpGet) begin
        r.status = body_addr(32'(it.rec_id), 32'(it.body_offset), a);
        if (r.status == trs_pkg::StOk) r.rd_byte = peek(a);
      end else if (it.op == trs_pkg::OpPut) begin
        r.status = body_addr(32'(it.rec_id), 32'(it.body_offset), a);
        if (r.status == trs_pkg::StOk) poke(a, it.wr_byte);
      end
      pending.push_back(r);
    endfunction

    // compare a result beat with the oldest prediction
    function void check_result(trs_pkg::out_t got);
      trs_pkg::out_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d rd_byte=%02h",
                 $time, got.status, got.rd_byte);
        return;
      end
      exp_r = pending.pop_front();
      n_checked++;
      if (got.status !== exp_r.status) begin
        errors++;
        $display("%0t: status mismatch expected %0d actual %0d",
                 $time, exp_r.status, got.status);
      end
      if (got.rd_byte !== exp_r.rd_byte) begin
        errors++;
        $display("%0t: rd_byte mismatch expected %02h actual %02h",
                 $time, exp_r.rd_byte, got.rd_byte);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  trs_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  trs_pkg::out_t out_data_o;

  int send_idle_pct;
  int recv_stall_pct;
  int n_sent;
  store_scoreboard sb;

  tagged_record_store #(.STORE_BYTES(StoreSz)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock, period 4
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: random stall, check accepted result beats
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // send one beat, with optional random idle cycles before it;
  // valid stays up after acceptance until the next beat or an idle
  task automatic send_beat(trs_pkg::in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
    n_sent++;
  endtask

  function automatic trs_pkg::in_t make_beat(logic [2:0] op, logic [15:0] id,
                                             logic [15:0] off, logic [15:0] sz,
                                             logic [7:0] wb);
    trs_pkg::in_t it;
    it.op = op;
    it.rec_id = id;
    it.body_offset = off;
    it.body_size = sz;
    it.wr_byte = wb;
    return it;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // random record traffic, ids from a small pool so that hits are common
  task automatic random_beats(int count);
    trs_pkg::in_t it;
    int           pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      it = make_beat(trs_pkg::OpGet, 16'($urandom_range(1, 6)),
                     16'($urandom_range(0, 15)),
                     16'($urandom_range(0, 40)), 8'($urandom));
      if (pick < 25) it.op = trs_pkg::OpCreate;
      else if (pick < 38) it.op = trs_pkg::OpDelete;
      else if (pick < 62) it.op = trs_pkg::OpGet;
      else if (pick < 92) it.op = trs_pkg::OpPut;
      else begin
        // noise: full-range fields, unused op codes
        it.wr_byte = 8'($urandom);
        it.op = 3'($urandom_range(5, 7));
        it.rec_id = 16'($urandom);
        it.body_offset = 16'($urandom);
        it.body_size = 16'($urandom);
      end
      if ($urandom_range(19) == 0) it.rec_id = 16'($urandom);
      if ($urandom_range(19) == 0) it.body_offset = 16'($urandom);
      send_beat(it);
    end
  endtask

  initial begin
    sb = new();
    n_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner fields and special cases
    send_beat(make_beat(trs_pkg::OpGet, 16'd1, 16'd0, 16'd0, 8'h00));       // empty store
    send_beat(make_beat(trs_pkg::OpCreate, 16'd0, 16'd0, 16'd4, 8'h00));    // id zero
    send_beat(make_beat(trs_pkg::OpDelete, 16'd0, 16'd0, 16'd0, 8'h00));
    send_beat(make_beat(trs_pkg::OpCreate, 16'hFFFF, 16'd0, 16'hFFFF, 8'h00)); // 64K
    send_beat(make_beat(trs_pkg::OpCreate, 16'd1, 16'd0, 16'd4093, 8'h00)); // past end
    send_beat(make_beat(trs_pkg::OpCreate, 16'd1, 16'd0, 16'd5, 8'h00));    // rounds to 8
    send_beat(make_beat(trs_pkg::OpCreate, 16'd1, 16'd0, 16'd8, 8'h00));    // duplicate
    send_beat(make_beat(trs_pkg::OpCreate, 16'hFFFF, 16'd0, 16'd0, 8'h00)); // empty body
    send_beat(make_beat(trs_pkg::OpCreate, 16'd2, 16'd0, 16'd3, 8'h00));
    send_beat(make_beat(trs_pkg::OpPut, 16'd1, 16'd7, 16'd0, 8'hFF));
    send_beat(make_beat(trs_pkg::OpPut, 16'd1, 16'd0, 16'd0, 8'hA5));
    send_beat(make_beat(trs_pkg::OpPut, 16'd1, 16'd8, 16'd0, 8'h5A));       // past body
    send_beat(make_beat(trs_pkg::OpGet, 16'hFFFF, 16'd0, 16'd0, 8'h00));    // empty body
    send_beat(make_beat(trs_pkg::OpPut, 16'd2, 16'hFFFF, 16'd0, 8'h11));
    send_beat(make_beat(trs_pkg::OpGet, 16'd1, 16'd7, 16'd0, 8'h00));
    send_beat(make_beat(trs_pkg::OpDelete, 16'd1, 16'd0, 16'd0, 8'h00));    // shift down
    send_beat(make_beat(trs_pkg::OpGet, 16'd1, 16'd0, 16'd0, 8'h00));
    send_beat(make_beat(trs_pkg::OpCreate, 16'd3, 16'd0, 16'd4084, 8'h00)); // overruns store
    send_beat(make_beat(trs_pkg::OpDelete, 16'd2, 16'd0, 16'd0, 8'h00));
    send_beat(make_beat(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));       // unused op
    send_beat(make_beat(3'd7, 16'd0, 16'd0, 16'd0, 8'h00));
    send_beat(make_beat(trs_pkg::OpDelete, 16'hFFFF, 16'd0, 16'd0, 8'h00));
    send_beat(make_beat(trs_pkg::OpDelete, 16'd3, 16'd0, 16'd0, 8'h00));

    // sender mostly busy, receiver stalls heavily
    send_idle_pct = 10;
    recv_stall_pct = 67;
    random_beats(40);
    // hold off until every prediction has come back
    drain();
    send_idle_pct = 67;
    recv_stall_pct = 10;
    random_beats(40);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_beats(35);

    // disable the store, then every record op must fail
    send_beat(make_beat(trs_pkg::OpInval, 16'd0, 16'd0, 16'd0, 8'h00));
    send_beat(make_beat(trs_pkg::OpGet, 16'd1, 16'd0, 16'd0, 8'h00));
    send_beat(make_beat(trs_pkg::OpCreate, 16'd9, 16'd0, 16'd4, 8'h00));
    send_beat(make_beat(trs_pkg::OpInval, 16'd0, 16'd0, 16'd0, 8'h00));
    send_beat(make_beat(trs_pkg::OpPut, 16'd1, 16'd0, 16'd0, 8'h00));
    send_beat(make_beat(trs_pkg::OpDelete, 16'd1, 16'd0, 16'd0, 8'h00));

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d beats, checked %0d results across three idling mixes.",
             n_sent, sb.n_checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("Timeout with %0d results outstanding", sb.pending.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
